### rtl/core/fis_pkg.sv
// package: shared types and constants of the flux interval statistics block
package fis_pkg;

	// sample limit per revolution and the counter width that holds it
	localparam int MAX_SAMPLES = 65536;
	localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);

	// field widths
	localparam int STAMP_W = 32;
	localparam int SUM_W   = 48;
	localparam int TOTAL_W = 17;
	localparam int RPM_W   = 44;

	// shared divider geometry
	localparam int DIV_N_W   = SUM_W;
	localparam int DIV_D_W   = 32;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam logic [RPM_W-1:0] RPM_NUM_RESET = 44'd4224422442244;

	// input beat
	typedef struct packed {
		logic [STAMP_W-1:0] timestamp;
		logic [STAMP_W-1:0] revolution_ticks;
		logic               last;
	} fis_in_t;

	// result beat
	typedef struct packed {
		logic [STAMP_W-1:0] gap_min;
		logic [STAMP_W-1:0] gap_max;
		logic [STAMP_W-1:0] gap_mean;
		logic [TOTAL_W-1:0] sample_total;
		logic [STAMP_W-1:0] span_ticks;
		logic [RPM_W-1:0]   rpm_fixed;
		logic               overrun;
	} fis_out_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_RPM_GO,
		ST_RPM_WAIT,
		ST_EMIT
	} fis_state_t;

endpackage

### rtl/core/fis_div.sv
// shared restoring divider, one quotient bit per cycle
module fis_div
	import fis_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               done,
	output logic [DIV_N_W-1:0] quotient
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_N_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_N_W-1:0]   quot_q;

	logic [DIV_D_W:0]     trial;
	logic [DIV_D_W:0]     diff;
	logic                 qbit;

	// trial subtraction of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, quot_q[DIV_N_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = !diff[DIV_D_W];
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= divisor;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quot_q <= {quot_q[DIV_N_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

### rtl/core/flux_interval_statistics.sv
// top level: interval statistics over the flux timestamps of one revolution
// a beat without last is folded in the cycle after it is taken, and in_ready returns in ST_IDLE
// a last beat with two or more samples runs two 48-step divisions on the shared divider
// (average, then rpm), through ST_FOLD, ST_AVG_GO, ST_AVG_WAIT, ST_RPM_GO, ST_RPM_WAIT and ST_EMIT
// a last beat with fewer than two samples goes from ST_FOLD to ST_EMIT and gives an all-zero result
// arst_n resets the revolution statistics and control and sets rpm_num_q to its reset value
module flux_interval_statistics
	import fis_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fis_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output fis_out_t         out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [RPM_W-1:0] cfg_data
);

	localparam logic [COUNT_W-1:0] SAMPLE_LIMIT = COUNT_W'(MAX_SAMPLES);
	localparam logic [COUNT_W-1:0] COUNT_TWO    = COUNT_W'(2);

	fis_state_t state_q, state_d;

	logic [RPM_W-1:0]   rpm_num_q;
	logic [STAMP_W-1:0] prev_q;
	logic [STAMP_W-1:0] min_q;
	logic [STAMP_W-1:0] max_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic               overrun_q;
	logic               has_delta_q;
	logic               last_q;
	logic [STAMP_W-1:0] delta_q;
	logic [STAMP_W-1:0] ticks_q;
	logic [STAMP_W-1:0] avg_q;
	logic [RPM_W-1:0]   rpm_q;
	logic               out_valid_q;
	fis_out_t           out_q;

	logic               in_fire;
	logic               out_load;
	logic               enough;
	logic               div_start;
	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quot;
	logic [SUM_W:0]     sum_ext;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign enough    = count_q >= COUNT_TWO;
	assign sum_ext   = {1'b0, sum_q} + (SUM_W+1)'(delta_q);

	// shared divider: average first, then rpm
	fis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		div_dividend = sum_q;
		div_divisor  = DIV_D_W'(count_q - 1'b1);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (enough) begin
					state_d = ST_AVG_GO;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_AVG_GO: begin
				div_start = 1'b1;
				state_d   = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (div_done) begin
					state_d = ST_RPM_GO;
				end
			end
			ST_RPM_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_N_W'(rpm_num_q);
				div_divisor  = ticks_q;
				state_d      = ST_RPM_WAIT;
			end
			ST_RPM_WAIT: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_num_q <= RPM_NUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rpm_num_q <= cfg_data;
		end
	end

	// revolution statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			overrun_q   <= 1'b0;
			has_delta_q <= 1'b0;
			last_q      <= 1'b0;
		end else if (in_fire) begin
			last_q <= in_data.last;
			if (count_q < SAMPLE_LIMIT) begin
				prev_q      <= in_data.timestamp;
				count_q     <= count_q + 1'b1;
				has_delta_q <= count_q != '0;
			end else begin
				overrun_q   <= 1'b1;
				has_delta_q <= 1'b0;
			end
		end else if (state_q == ST_FOLD && has_delta_q) begin
			if (delta_q < min_q) begin
				min_q <= delta_q;
			end
			if (delta_q > max_q) begin
				max_q <= delta_q;
			end
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end else if (out_load) begin
			prev_q      <= '0;
			min_q       <= '1;
			max_q       <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			overrun_q   <= 1'b0;
			has_delta_q <= 1'b0;
		end
	end

	// per-beat payload and division results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			delta_q <= in_data.timestamp - prev_q;
			ticks_q <= in_data.revolution_ticks;
		end
		if (state_q == ST_AVG_WAIT && div_done) begin
			avg_q <= (div_quot[DIV_N_W-1:STAMP_W] != '0) ? '1 : div_quot[STAMP_W-1:0];
		end
		if (state_q == ST_RPM_WAIT && div_done) begin
			rpm_q <= div_quot[RPM_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (enough) begin
				out_q.gap_min      <= min_q;
				out_q.gap_max      <= max_q;
				out_q.gap_mean     <= avg_q;
				out_q.sample_total <= TOTAL_W'(count_q);
				out_q.span_ticks   <= ticks_q;
				out_q.rpm_fixed    <= (ticks_q != '0) ? rpm_q : '0;
				out_q.overrun      <= overrun_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/fis_checker.sv
// checker on the ports of the flux interval statistics block, with its bind
module fis_checker
	import fis_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input fis_out_t         out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// every accepted beat is folded before the next one is taken
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken in the fold cycle");

	// a short revolution gives an all-zero result
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_total == '0 |->
		out_data.gap_min == '0 && out_data.gap_max == '0 &&
		out_data.gap_mean == '0 && out_data.span_ticks == '0 &&
		out_data.rpm_fixed == '0 && !out_data.overrun)
		else $error("short revolution with non-zero fields");

	// the mean lies between the extremes
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_total != '0 |->
		out_data.gap_min <= out_data.gap_mean && out_data.gap_mean <= out_data.gap_max)
		else $error("average outside min and max");

	// no revolution ticks, no rpm
	a_zero_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.span_ticks == '0 |-> out_data.rpm_fixed == '0)
		else $error("rpm given for zero ticks");

endmodule

bind flux_interval_statistics fis_checker u_fis_checker (.*);

### test/tb.sv
// testbench: flux interval statistics checked beat by beat against an in-bench predictor
`timescale 1ns / 100ps

module tb;
	import fis_pkg::*;

	// flux gap profiles used to build revolutions
	typedef enum int {
		GAP_FLUX,
		GAP_WILD,
		GAP_MIXED
	} gap_kind_t;

	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_BEATS   = 550;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	fis_in_t          in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	fis_out_t         out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [RPM_W-1:0] cfg_data  = '0;

	flux_interval_statistics uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// flux beats waiting for the driver and statistics waiting for the block
	fis_in_t  flux_beats[$];
	fis_out_t stats_due[$];

	// predictor copy of the revolution state and the register
	logic [RPM_W-1:0]   rpm_num  = RPM_NUM_RESET;
	logic [STAMP_W-1:0] rev_prev = '0;
	logic [STAMP_W-1:0] rev_min  = '1;
	logic [STAMP_W-1:0] rev_max  = '0;
	logic [SUM_W-1:0]   rev_sum  = '0;
	int unsigned        rev_count = 0;
	bit                 rev_over  = 1'b0;

	bit beat_held     = 1'b0;
	int send_idle_pct = 23;
	int recv_idle_pct = 78;
	int beats_queued  = 0;
	int beats_sent    = 0;
	int revs_checked  = 0;
	int num_writes    = 0;
	int bad_fields    = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(8_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	// fold one accepted beat into the predicted revolution state
	function automatic void fold_flux_beat(input fis_in_t b);
		logic [STAMP_W-1:0] gap;
		logic [SUM_W:0]     grown;
		longint unsigned    quot;
		fis_out_t           r;
		if (rev_count < MAX_SAMPLES) begin
			if (rev_count > 0) begin
				gap = b.timestamp - rev_prev;
				if (gap < rev_min)
					rev_min = gap;
				if (gap > rev_max)
					rev_max = gap;
				grown = {1'b0, rev_sum} + gap;
				rev_sum = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
			end
			rev_prev = b.timestamp;
			rev_count++;
		end else begin
			rev_over = 1'b1;
		end
		if (b.last) begin
			r = '0;
			if (rev_count >= 2) begin
				quot = 64'(rev_sum) / 64'(rev_count - 1);
				r.gap_min      = rev_min;
				r.gap_max      = rev_max;
				r.gap_mean     = (quot > 64'hFFFF_FFFF) ? '1 : quot[STAMP_W-1:0];
				r.sample_total = rev_count[TOTAL_W-1:0];
				r.span_ticks   = b.revolution_ticks;
				quot = (b.revolution_ticks != 0) ?
					64'(rpm_num) / 64'(b.revolution_ticks) : 64'd0;
				r.rpm_fixed = quot[RPM_W-1:0];
				r.overrun   = rev_over;
			end
			stats_due.push_back(r);
			// back to a fresh revolution
			rev_prev  = '0;
			rev_min   = '1;
			rev_max   = '0;
			rev_sum   = '0;
			rev_count = 0;
			rev_over  = 1'b0;
		end
	endfunction

	function automatic int field_bad(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		return 1;
	endfunction

	// input driver: new beat or idle at the falling edge, held until taken
	always @(negedge clk) begin
		if (arst_n && !beat_held) begin
			if (flux_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= flux_beats.pop_front();
				in_valid <= 1'b1;
				beat_held = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// input monitor: predict on every accepted beat
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			fold_flux_beat(in_data);
			beats_sent++;
			beat_held = 1'b0;
		end
	end

	// result monitor: compare each statistics beat with the oldest prediction
	always @(posedge clk) begin : check_stats
		fis_out_t want;
		int       bad;
		if (arst_n && out_valid && out_ready) begin
			if (stats_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h",
					$time, out_data);
				bad_fields++;
			end else begin
				want = stats_due.pop_front();
				bad  = field_bad("gap_min", want.gap_min, out_data.gap_min);
				bad += field_bad("gap_max", want.gap_max, out_data.gap_max);
				bad += field_bad("gap_mean", want.gap_mean, out_data.gap_mean);
				bad += field_bad("sample_total", want.sample_total, out_data.sample_total);
				bad += field_bad("span_ticks", want.span_ticks, out_data.span_ticks);
				bad += field_bad("rpm_fixed", want.rpm_fixed, out_data.rpm_fixed);
				bad += field_bad("overrun", want.overrun, out_data.overrun);
				bad_fields += bad;
				revs_checked++;
			end
		end
	end

	task automatic push_beat(input logic [STAMP_W-1:0] stamp,
			input logic [STAMP_W-1:0] ticks, input logic last);
		fis_in_t b;
		b.timestamp        = stamp;
		b.revolution_ticks = ticks;
		b.last             = last;
		flux_beats.push_back(b);
		beats_queued++;
	endtask

	// one revolution of n samples, ticks given on the closing beat
	task automatic push_revolution(input int n, input gap_kind_t kind,
			input logic [STAMP_W-1:0] ticks);
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] gap;
		stamp = $urandom;
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				case (kind)
					GAP_FLUX: gap = $urandom_range(700, 40);
					GAP_WILD: gap = $urandom;
					default:  gap = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
				endcase
				stamp = stamp + gap;
			end
			push_beat(stamp, (i == n - 1) ? ticks : $urandom, i == n - 1);
		end
	endtask

	function automatic logic [STAMP_W-1:0] pick_ticks();
		case ($urandom_range(5))
			0:       return '0;
			1:       return $urandom_range(16, 1);
			2:       return '1;
			3:       return $urandom;
			default: return $urandom_range(60_000_000, 40_000_000);
		endcase
	endfunction

	// random revolutions, mostly short, some long, a few of one or two samples
	task automatic push_random_revs(input int beats);
		int        stop;
		int        pick;
		int        n;
		gap_kind_t kind;
		stop = beats_queued + beats;
		while (beats_queued < stop) begin
			pick = $urandom_range(9);
			if (pick == 0)
				n = $urandom_range(2, 1);
			else if (pick < 8)
				n = $urandom_range(40, 3);
			else
				n = $urandom_range(200, 41);
			case ($urandom_range(3))
				0:       kind = GAP_WILD;
				1:       kind = GAP_MIXED;
				default: kind = GAP_FLUX;
			endcase
			push_revolution(n, kind, pick_ticks());
		end
	endtask

	// wait for every beat to go in and every result to come out, then let the block finish
	task automatic drain_all();
		while (flux_beats.size() > 0 || beat_held || stats_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rpm_numerator(input logic [RPM_W-1:0] value);
		drain_all();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		rpm_num = value;
		num_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		logic [RPM_W-1:0] wide;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single sample gives all zeros
		push_beat(32'h0000_1234, 32'd5, 1'b1);
		// wrapping gap, zero ticks
		push_beat(32'hFFFF_FFF0, 32'h0, 1'b0);
		push_beat(32'h0000_0010, 32'h0, 1'b1);
		// largest gap, one tick
		push_beat(32'h0000_0001, 32'h0, 1'b0);
		push_beat(32'h0000_0000, 32'h1, 1'b1);
		// zero and largest gap together, largest ticks
		push_beat(32'h0000_0005, 32'hFFFF_FFFF, 1'b0);
		push_beat(32'h0000_0005, 32'hFFFF_FFFF, 1'b0);
		push_beat(32'h0000_0004, 32'hFFFF_FFFF, 1'b1);
		// ordinary flux revolution
		push_revolution(5, GAP_FLUX, 32'd55_000_000);

		// zero numerator
		write_rpm_numerator('0);
		push_beat(32'h0000_0100, 32'h0, 1'b0);
		push_beat(32'h0000_0300, 32'd1000, 1'b1);
		// largest numerator over one tick
		write_rpm_numerator('1);
		push_beat(32'hFFFF_FFFF, 32'h0, 1'b0);
		push_beat(32'h0000_0000, 32'h1, 1'b1);
		// smallest numerator
		write_rpm_numerator(44'd1);
		push_beat(32'h8000_0000, 32'h0, 1'b0);
		push_beat(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		push_beat(32'h0000_0000, 32'h0, 1'b0);
		push_beat(32'h0000_0001, 32'h1, 1'b1);

		// sender busy, receiver stalling hard; pause half way for everything to drain
		write_rpm_numerator(RPM_NUM_RESET);
		push_random_revs(PHASE_BEATS / 2);
		drain_all();
		push_random_revs(PHASE_BEATS / 2);

		// roles swapped, random numerator
		wide = RPM_W'({$urandom, $urandom});
		write_rpm_numerator(wide);
		send_idle_pct = 78;
		recv_idle_pct = 23;
		push_random_revs(PHASE_BEATS);

		// no idling, largest numerator
		write_rpm_numerator('1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_revs(PHASE_BEATS);

		drain_all();
		$display("covered %0d beats over %0d revolutions", beats_sent, revs_checked);
		$display("with %0d numerator writes and three idling profiles", num_writes);
		if (bad_fields == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
